// ----- hdl/svgax_pkg.sv -----
// shared types, constants and the crtc write-mask table of the svga extended register file
// no dependencies; used by svgax_crtc_store, svgax_exec and svga_extended_register_file
package svgax_pkg;

    // crtc register file depth (32 to 64) and its address width
    localparam int CRTC_REGS = 64;
    localparam int CRTC_AW   = $clog2(CRTC_REGS);

    // stream widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // i/o ports
    localparam logic [9:0] PORT_LOW    = 10'h3B0;
    localparam logic [9:0] PORT_HIGH   = 10'h3DF;
    localparam logic [9:0] PORT_MONO   = 10'h3B0;
    localparam logic [9:0] PORT_COLOR  = 10'h3D0;
    localparam logic [9:0] PORT_GROUP  = 10'h3F0;
    localparam logic [9:0] PORT_REMAP  = 10'h060;
    localparam logic [9:0] PORT_MISC_W = 10'h3C2;
    localparam logic [9:0] PORT_SEQ_I  = 10'h3C4;
    localparam logic [9:0] PORT_SEQ_D  = 10'h3C5;
    localparam logic [9:0] PORT_DAC_0  = 10'h3C6;
    localparam logic [9:0] PORT_DAC_1  = 10'h3C7;
    localparam logic [9:0] PORT_DAC_2  = 10'h3C8;
    localparam logic [9:0] PORT_DAC_3  = 10'h3C9;
    localparam logic [9:0] PORT_GDC_I  = 10'h3CE;
    localparam logic [9:0] PORT_GDC_D  = 10'h3CF;
    localparam logic [9:0] PORT_CRTC_I = 10'h3D4;
    localparam logic [9:0] PORT_CRTC_D = 10'h3D5;
    localparam logic [9:0] PORT_BANK_W = 10'h3D8;
    localparam logic [9:0] PORT_BANK_R = 10'h3D9;
    localparam logic [9:0] PORT_CLK_EX = 10'h3DB;

    // sequencer and graphics extension indices
    localparam logic [3:0] SEQ_VERSION = 4'hB;
    localparam logic [3:0] SEQ_PWR_UP  = 4'hC;
    localparam logic [3:0] SEQ_CTRL2   = 4'hD;
    localparam logic [3:0] SEQ_CTRL1   = 4'hE;
    localparam logic [3:0] GDC_EXT_E   = 4'hE;
    localparam logic [3:0] GDC_EXT_F   = 4'hF;

    // crtc indices with special handling
    localparam logic [5:0] CRTC_OVERFLOW  = 6'h07;
    localparam logic [5:0] CRTC_VRET_END  = 6'h11;
    localparam logic [5:0] CRTC_FULL_VRAM = 6'h1E;
    localparam logic [5:0] CRTC_FF_LOW    = 6'h19;
    localparam logic [5:0] CRTC_FF_HIGH   = 6'h1D;
    localparam logic [5:0] CRTC_NOTCH_LO  = 6'h0E;
    localparam logic [5:0] CRTC_NOTCH_HI  = 6'h10;

    localparam logic [7:0] CHIP_ID_8900 = 8'h33;
    localparam logic [7:0] CHIP_ID_9000 = 8'h23;
    localparam logic       CHIP_8900    = 1'b0;

    localparam logic       CMD_READ  = 1'b0;
    localparam logic       CMD_WRITE = 1'b1;

    typedef struct packed {
        logic       command;
        logic [9:0] port;
        logic [7:0] write_data;
    } item_t;

    // read_data in the lowest bits
    typedef struct packed {
        logic       full_vram_display;
        logic       timing_changed;
        logic [3:0] clock_select;
        logic [4:0] read_bank;
        logic [4:0] write_bank;
        logic       forward_to_ramdac;
        logic       forward_to_base;
        logic [7:0] read_data;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // register state kept in flops; crtc_prot and crtc_full mirror crtc bits that
    // the logic needs every cycle
    typedef struct packed {
        logic [3:0] seq_index;
        logic [3:0] gdc_index;
        logic [7:0] misc_output;
        logic [5:0] crtc_index;
        logic       old_mode;
        logic [7:0] old_ctrl_one;
        logic [7:0] old_ctrl_two;
        logic [7:0] new_ctrl_two;
        logic [7:0] seq_power_up;
        logic [7:0] seq_mode_ext;
        logic [7:0] gdc_ext_e;
        logic [7:0] gdc_ext_f;
        logic [7:0] bank_write;
        logic [7:0] bank_read;
        logic       crtc_prot;
        logic       crtc_full;
    } ext_state_t;

    typedef struct packed {
        logic               we;
        logic [CRTC_AW-1:0] addr;
        logic [7:0]         data;
    } crtc_wr_t;

    // writable bits of each crtc register
    function automatic logic [7:0] crtc_wmask(input logic [5:0] idx);
        logic [7:0] m;
        case (idx) inside
            [6'h00:6'h07], 6'h09, [6'h0C:6'h13], 6'h15, 6'h16, 6'h18, 6'h1E, 6'h1F:
                m = 8'hFF;
            6'h08, 6'h0B, 6'h14, 6'h20: m = 8'h7F;
            6'h0A:                      m = 8'h3F;
            6'h17:                      m = 8'hEF;
            6'h23:                      m = 8'h2F;
            6'h27:                      m = 8'h03;
            6'h29:                      m = 8'h13;
            default:                    m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

// ----- hdl/svgax_crtc_store.sv -----
// crtc register memory: one write and one registered read port, write-first on collision
// uses svgax_pkg; entries read as zero until written (per-entry valid bits)
module svgax_crtc_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  svgax_pkg::crtc_wr_t          wr,
    input  logic                         rd_en,
    input  logic [svgax_pkg::CRTC_AW-1:0] rd_addr,
    output logic [7:0]                   rd_data
);

    logic [7:0]                     mem [svgax_pkg::CRTC_REGS];
    logic [svgax_pkg::CRTC_REGS-1:0] valid_reg;
    logic [7:0]                     rdata_reg;
    logic                           rvalid_reg;
    logic                           collide;

    assign collide = wr.we && (wr.addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rdata_reg <= collide ? wr.data : mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= collide || valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : 8'h00;

endmodule

// ----- hdl/svgax_exec.sv -----
// execution of one port access: remap, decode, register update and result
// uses svgax_pkg; purely combinational, state is held by the top level
module svgax_exec (
    input  logic                  chip_model,
    input  svgax_pkg::ext_state_t st,
    input  svgax_pkg::item_t      item,
    input  logic [7:0]            crtc_rdata,
    output svgax_pkg::ext_state_t st_next,
    output svgax_pkg::crtc_wr_t   crtc_wr,
    output svgax_pkg::result_t    result
);

    logic [9:0] addr;
    logic       in_range;
    logic       crtc_in_range;
    logic       fwd;
    logic       ramdac;
    logic       tch;
    logic [7:0] rd;
    logic [7:0] v;
    logic [7:0] nv;
    logic [5:0] idx;
    logic [4:0] wb;

    assign in_range = (item.port >= svgax_pkg::PORT_LOW) && (item.port <= svgax_pkg::PORT_HIGH);
    assign idx      = st.crtc_index;
    assign v        = item.write_data;
    assign crtc_in_range = (7'(idx) < 7'(svgax_pkg::CRTC_REGS));

    // mono/color remap
    always_comb
    begin
        addr = item.port;
        if ((((item.port & svgax_pkg::PORT_GROUP) == svgax_pkg::PORT_COLOR)
            || ((item.port & svgax_pkg::PORT_GROUP) == svgax_pkg::PORT_MONO))
            && !st.misc_output[0])
        begin
            addr = item.port ^ svgax_pkg::PORT_REMAP;
        end
    end

    always_comb
    begin
        st_next = st;
        crtc_wr = '{we: 1'b0, addr: idx[svgax_pkg::CRTC_AW-1:0], data: 8'h00};
        fwd     = 1'b0;
        ramdac  = 1'b0;
        tch     = 1'b0;
        rd      = 8'h00;
        nv      = v;

        if (in_range && item.command == svgax_pkg::CMD_WRITE)
        begin
            fwd = 1'b1;
            unique case (addr)
                svgax_pkg::PORT_MISC_W:
                begin
                    st_next.misc_output = v;
                    tch = 1'b1;
                end
                svgax_pkg::PORT_SEQ_I: st_next.seq_index = v[3:0];
                svgax_pkg::PORT_GDC_I: st_next.gdc_index = v[3:0];
                svgax_pkg::PORT_SEQ_D:
                begin
                    unique case (st.seq_index)
                        svgax_pkg::SEQ_VERSION: st_next.old_mode = 1'b1;
                        svgax_pkg::SEQ_PWR_UP:
                        begin
                            if (st.seq_mode_ext[7])
                            begin
                                st_next.seq_power_up = v;
                            end
                        end
                        svgax_pkg::SEQ_CTRL2:
                        begin
                            if (st.old_mode)
                            begin
                                st_next.old_ctrl_two = v;
                            end
                            else
                            begin
                                st_next.new_ctrl_two = v;
                                tch = 1'b1;
                            end
                        end
                        svgax_pkg::SEQ_CTRL1:
                        begin
                            fwd = 1'b0;
                            if (st.old_mode)
                            begin
                                st_next.old_ctrl_one = v;
                                tch = 1'b1;
                            end
                            else
                            begin
                                st_next.seq_mode_ext = v ^ 8'h02;
                                st_next.bank_write   = {4'h0, v[3:2], ~v[1], v[0]};
                            end
                        end
                        default: ;
                    endcase
                end
                svgax_pkg::PORT_DAC_0, svgax_pkg::PORT_DAC_1,
                svgax_pkg::PORT_DAC_2, svgax_pkg::PORT_DAC_3:
                begin
                    if (chip_model == svgax_pkg::CHIP_8900)
                    begin
                        ramdac = 1'b1;
                        fwd    = 1'b0;
                    end
                end
                svgax_pkg::PORT_GDC_D:
                begin
                    if (st.gdc_index == svgax_pkg::GDC_EXT_E)
                    begin
                        st_next.gdc_ext_e = v ^ 8'h02;
                        st_next.bank_read = {4'h0, v[3:2], ~v[1], v[0]};
                    end
                    else if (st.gdc_index == svgax_pkg::GDC_EXT_F)
                    begin
                        st_next.gdc_ext_f = v;
                    end
                end
                svgax_pkg::PORT_CRTC_I:
                begin
                    st_next.crtc_index = v[5:0];
                    fwd = 1'b0;
                end
                svgax_pkg::PORT_CRTC_D:
                begin
                    fwd = 1'b0;
                    if (crtc_in_range && !(idx < svgax_pkg::CRTC_OVERFLOW && st.crtc_prot))
                    begin
                        // protected overflow register keeps all but the line-compare bit
                        if (idx == svgax_pkg::CRTC_OVERFLOW && st.crtc_prot)
                        begin
                            nv = (crtc_rdata & 8'hEF) | (v & 8'h10);
                        end
                        nv = nv & svgax_pkg::crtc_wmask(idx);
                        crtc_wr.we   = 1'b1;
                        crtc_wr.data = nv;
                        if (idx == svgax_pkg::CRTC_VRET_END)
                        begin
                            st_next.crtc_prot = nv[7];
                        end
                        if (idx == svgax_pkg::CRTC_FULL_VRAM)
                        begin
                            st_next.crtc_full = nv[7];
                        end
                        if (nv != crtc_rdata
                            && (idx < svgax_pkg::CRTC_NOTCH_LO || idx > svgax_pkg::CRTC_NOTCH_HI))
                        begin
                            tch = 1'b1;
                        end
                    end
                end
                svgax_pkg::PORT_BANK_W:
                begin
                    fwd = 1'b0;
                    if (st.gdc_ext_f[2])
                    begin
                        st_next.bank_write = v;
                    end
                end
                svgax_pkg::PORT_BANK_R:
                begin
                    fwd = 1'b0;
                    if (st.gdc_ext_f[2])
                    begin
                        st_next.bank_read = v;
                    end
                end
                svgax_pkg::PORT_CLK_EX:
                begin
                    if (chip_model == svgax_pkg::CHIP_8900)
                    begin
                        st_next.misc_output[3:2] = v[1:0];
                        st_next.new_ctrl_two[0]  = v[2];
                        st_next.old_ctrl_one[4]  = v[3];
                        tch = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        else if (in_range)
        begin
            fwd = 1'b0;
            unique case (addr)
                svgax_pkg::PORT_SEQ_D:
                begin
                    unique case (st.seq_index)
                        svgax_pkg::SEQ_VERSION:
                        begin
                            st_next.old_mode = 1'b0;
                            rd = chip_model ? svgax_pkg::CHIP_ID_9000 : svgax_pkg::CHIP_ID_8900;
                        end
                        svgax_pkg::SEQ_PWR_UP: rd = st.seq_power_up;
                        svgax_pkg::SEQ_CTRL2:  rd = st.old_mode ? st.old_ctrl_two : st.new_ctrl_two;
                        svgax_pkg::SEQ_CTRL1:  rd = st.old_mode ? st.old_ctrl_one : st.seq_mode_ext;
                        default:               fwd = 1'b1;
                    endcase
                end
                svgax_pkg::PORT_DAC_0, svgax_pkg::PORT_DAC_1,
                svgax_pkg::PORT_DAC_2, svgax_pkg::PORT_DAC_3:
                begin
                    if (chip_model == svgax_pkg::CHIP_8900)
                    begin
                        ramdac = 1'b1;
                    end
                    else
                    begin
                        fwd = 1'b1;
                    end
                end
                svgax_pkg::PORT_GDC_D:
                begin
                    if (st.gdc_index == svgax_pkg::GDC_EXT_E)
                    begin
                        rd = st.gdc_ext_e;
                    end
                    else if (st.gdc_index == svgax_pkg::GDC_EXT_F)
                    begin
                        rd = st.gdc_ext_f;
                    end
                    else
                    begin
                        fwd = 1'b1;
                    end
                end
                svgax_pkg::PORT_CRTC_I: rd = {2'b00, st.crtc_index};
                svgax_pkg::PORT_CRTC_D:
                begin
                    if (idx >= svgax_pkg::CRTC_FF_LOW && idx <= svgax_pkg::CRTC_FF_HIGH)
                    begin
                        rd = 8'hFF;
                    end
                    else if (crtc_in_range)
                    begin
                        rd = crtc_rdata;
                    end
                end
                svgax_pkg::PORT_BANK_W: rd = st.bank_write;
                svgax_pkg::PORT_BANK_R: rd = st.bank_read;
                default:                fwd = 1'b1;
            endcase
        end
    end

    assign wb = st_next.bank_write[4:0];

    always_comb
    begin
        result.read_data         = rd;
        result.forward_to_base   = fwd;
        result.forward_to_ramdac = ramdac;
        result.write_bank        = wb;
        result.read_bank         = st_next.gdc_ext_f[0] ? st_next.bank_read[4:0] : wb;
        result.clock_select      = {chip_model ? st_next.new_ctrl_two[6] : st_next.old_ctrl_one[4],
                                    st_next.new_ctrl_two[0], st_next.misc_output[3:2]};
        result.timing_changed    = tch;
        result.full_vram_display = st_next.crtc_full;
    end

endmodule

// ----- hdl/svga_extended_register_file.sv -----
// top level of the svga extended register file: stream ports, state registers, output register
// uses svgax_pkg, svgax_crtc_store and svgax_exec
// an accepted access is registered while its crtc entry is read, then executes into out_reg
// throughput: one access per cycle unless output stalls; crtc index of the executing access
//   feeds the read address of the write-first memory, so back-to-back crtc accesses agree
// reset (rst_n low, asynchronous): state and control registers zero, chip_model 8900D,
//   crtc entries read as zero until written; no clearing pass
module svga_extended_register_file (
    input  logic        clk,
    input  logic        rst_n,
    // chip_model write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,       // [0] chip_model
    // access stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [9:0] port, [17:10] write_data, rest zero
    input  logic        s_axis_tuser,   // [0] command
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [7:0] read_data, [8] forward_to_base,
                                        // [9] forward_to_ramdac, [14:10] write_bank,
                                        // [19:15] read_bank, [23:20] clock_select,
                                        // [24] timing_changed, [25] full_vram_display
);

    svgax_pkg::ext_state_t st_reg;
    svgax_pkg::ext_state_t st_next;
    svgax_pkg::item_t      item_reg;
    svgax_pkg::result_t    out_reg;
    svgax_pkg::result_t    result;
    svgax_pkg::crtc_wr_t   exec_wr;
    svgax_pkg::crtc_wr_t   crtc_wr;
    logic                  chip_model_reg;
    logic                  item_valid_reg;
    logic                  out_valid_reg;
    logic                  advance;
    logic                  accept;
    logic [5:0]            rd_index;
    logic [7:0]            crtc_rdata;

    // stage one holds the accepted access while its crtc entry is read;
    // it executes when the output register is free or being drained
    assign advance       = item_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // read the entry the next access will see: index after the executing access
    assign rd_index = advance ? st_next.crtc_index : st_reg.crtc_index;

    always_comb
    begin
        crtc_wr    = exec_wr;
        crtc_wr.we = exec_wr.we && advance;
    end

    svgax_crtc_store u_crtc (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (crtc_wr),
        .rd_en   (accept),
        .rd_addr (rd_index[svgax_pkg::CRTC_AW-1:0]),
        .rd_data (crtc_rdata)
    );

    svgax_exec u_exec (
        .chip_model (chip_model_reg),
        .st         (st_reg),
        .item       (item_reg),
        .crtc_rdata (crtc_rdata),
        .st_next    (st_next),
        .crtc_wr    (exec_wr),
        .result     (result)
    );

    // control and register state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= '0;
            chip_model_reg <= 1'b0;
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                chip_model_reg <= cfg_data;
            end
            if (advance)
            begin
                st_reg <= st_next;
            end
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.command    <= s_axis_tuser;
            item_reg.port       <= s_axis_tdata[9:0];
            item_reg.write_data <= s_axis_tdata[17:10];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(svgax_pkg::OUT_TDATA_W - svgax_pkg::RESULT_W)'(0), out_reg};

    // an accepted access always occupies stage one on the next cycle
    a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> item_valid_reg)
        else $error("accepted access not held in stage one");

    // an executed access always lands in the output register
    a_exec_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("executed access lost before output register");

    // an access goes either to the base vga or to the ramdac, never both
    a_fwd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.forward_to_base && out_reg.forward_to_ramdac))
        else $error("access forwarded to base vga and ramdac at once");

    // the crtc memory is only written by an executing access
    a_write_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        crtc_wr.we |-> item_valid_reg)
        else $error("crtc write without an executing access");

endmodule
